// File: hw/rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int MAX_SEGMENTS = 32;
	localparam int PAGE_BYTES   = 4096;
	localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);

	localparam int ADDR_W   = 32;
	localparam int PAGES_W  = 21;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = $clog2(MAX_SEGMENTS);
	localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
	localparam int END_W    = ((ADDR_W > PAGES_W + PAGE_SHIFT) ? ADDR_W
		: (PAGES_W + PAGE_SHIFT)) + 1;

	localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FREE    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  address;
		logic [PAGES_W-1:0] pages;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   result_base;
		logic [PAGES_W-1:0]  result_pages;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  base;
		logic [PAGES_W-1:0] pages;
		logic               in_use;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

endpackage

// File: hw/rtl/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: hw/rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// Ordered segment table in one RAM; a sequencer scans it, then shifts
// entries and writes the new pieces back.
// ----------------------------------------------------------------------------
//  channel | signals                  | direction | payload
//  req     | req_valid, req_stall     | in        | req_t (kind, address, pages)
//  rsp     | rsp_valid, rsp_stall     | out       | rsp_t (status, base, pages)
//
// Each item scans table entries through the single RAM read port, moves
// entries on insertion or removal, writes its new pieces and then hands
// over the result. The scan and the moves together pass over each entry
// once. Reset empties the table at once; the RAM contents need no
// clearing. A new item is taken while the result of the previous one
// still waits in the output register.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
	import ffsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_EV   = 4'd2;
	localparam logic [3:0] S_RDN  = 4'd3;
	localparam logic [3:0] S_EVN  = 4'd4;
	localparam logic [3:0] S_SHR  = 4'd5;
	localparam logic [3:0] S_SHW  = 4'd6;
	localparam logic [3:0] S_PW   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	function automatic logic [END_W-1:0] ext_addr(input logic [ADDR_W-1:0] a);
		return {{(END_W-ADDR_W){1'b0}}, a};
	endfunction

	function automatic logic [END_W-1:0] page_bytes(input logic [PAGES_W-1:0] p);
		return {{(END_W-PAGES_W-PAGE_SHIFT){1'b0}}, p, {PAGE_SHIFT{1'b0}}};
	endfunction

	logic [3:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [KIND_W-1:0]   kind_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [PAGES_W-1:0]  n_q;
	logic [END_W-1:0]    rend_q;
	logic [CNT_W-1:0]    idx_q;
	seg_t                prev_q;
	logic [END_W-1:0]    prev_end_q;
	logic                prev_ok_q;
	logic [END_W-1:0]    cur_end_q;
	logic                mp_q;
	logic [ADDR_W-1:0]   mbase_q;
	logic [PAGES_W-1:0]  mpages_q;
	seg_t                piece_q [3];
	logic [1:0]          wn_q;
	logic [1:0]          pw_q;
	logic [IDX_W-1:0]    wstart_q;
	logic                up_q;
	logic [1:0]          amt_q;
	logic [CNT_W-1:0]    sstart_q;
	logic [CNT_W-1:0]    k_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   rbase_q;
	logic [PAGES_W-1:0]  rpages_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [SEG_W-1:0] rd_raw;
	logic [SEG_W-1:0] wr_raw;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;
	seg_t             e;
	logic [END_W-1:0] e_end;
	logic [CNT_W-1:0] next_i;
	logic [CNT_W-1:0] sh_src;
	logic [CNT_W-1:0] sh_dst;
	logic [CNT_W-1:0] pw_dst;
	logic             sh_more;

	logic [PAGES_W:0]    psum;
	logic [PAGES_W:0]    nsum;
	logic [ADDR_W-1:0]   rdiff;
	logic [PAGES_W-1:0]  head;
	logic                has_head;
	logic                has_tail;
	logic [1:0]          need;
	logic                has_next;
	logic                mn;
	logic [PAGES_W-1:0]  fpages;

	ffsa_ram #(
		.WIDTH(SEG_W),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_raw),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign e        = seg_t'(rd_raw);
	assign e_end    = ext_addr(e.base) + page_bytes(e.pages);
	assign next_i   = idx_q + CNT_W'(1);
	assign sh_src   = up_q ? (k_q - CNT_W'(1)) : k_q;
	assign sh_dst   = up_q ? (k_q - CNT_W'(1) + CNT_W'(amt_q)) : (k_q - CNT_W'(amt_q));
	assign pw_dst   = CNT_W'(wstart_q) + CNT_W'(pw_q);
	assign sh_more  = up_q ? (k_q > sstart_q) : (k_q < cnt_q);

	assign psum     = {1'b0, prev_q.pages} + {1'b0, e.pages};
	assign nsum     = {1'b0, mpages_q} + {1'b0, e.pages};
	assign rdiff    = addr_q - e.base;
	assign head     = PAGES_W'(rdiff >> PAGE_SHIFT);
	assign has_head = addr_q != e.base;
	assign has_tail = rend_q < e_end;
	assign need     = {1'b0, has_head} + {1'b0, has_tail};
	assign has_next = next_i < cnt_q;
	assign mn       = has_next && !e.in_use && (cur_end_q == ext_addr(e.base)) &&
		!nsum[PAGES_W];
	assign fpages   = mn ? nsum[PAGES_W-1:0] : mpages_q;

	always_comb begin
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = pw_dst[IDX_W-1:0];
		wr_raw  = piece_q[pw_q];
		unique case (state_q)
			S_RDN: begin
				rd_addr = next_i[IDX_W-1:0];
			end
			S_SHR: begin
				rd_addr = sh_src[IDX_W-1:0];
			end
			S_SHW: begin
				wr_en   = 1'b1;
				wr_addr = sh_dst[IDX_W-1:0];
				wr_raw  = rd_raw;
			end
			S_PW: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE) begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_q <= 1'b1;
				end
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q    <= req.kind;
						addr_q    <= req.address;
						n_q       <= req.pages;
						rend_q    <= ext_addr(req.address) + page_bytes(req.pages);
						idx_q     <= '0;
						prev_ok_q <= 1'b0;
						rbase_q   <= '0;
						pw_q      <= '0;
						if (req.kind == KIND_ADD) begin
							if (cnt_q >= CNT_W'(MAX_SEGMENTS)) begin
								status_q <= ST_FULL;
								rpages_q <= '0;
								state_q  <= S_DONE;
							end else begin
								piece_q[0] <= '{base: req.address, pages: req.pages,
									in_use: 1'b0};
								wn_q     <= 2'd1;
								wstart_q <= '0;
								up_q     <= 1'b1;
								amt_q    <= 2'd1;
								sstart_q <= '0;
								k_q      <= cnt_q;
								status_q <= ST_DONE;
								rpages_q <= req.pages;
								state_q  <= S_SHR;
							end
						end else begin
							status_q <= ST_NONE;
							rpages_q <= '0;
							if (cnt_q == '0 ||
								(req.kind != KIND_FREE && req.pages == '0)) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					priority if (kind_q == KIND_ALLOC && !e.in_use && e.pages >= n_q) begin
						if (e.pages != n_q && cnt_q >= CNT_W'(MAX_SEGMENTS)) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							piece_q[0] <= '{base: e.base, pages: n_q, in_use: 1'b1};
							piece_q[1] <= '{base: ADDR_W'(ext_addr(e.base) +
								page_bytes(n_q)),
								pages: e.pages - n_q, in_use: 1'b0};
							wn_q     <= (e.pages != n_q) ? 2'd2 : 2'd1;
							amt_q    <= (e.pages != n_q) ? 2'd1 : 2'd0;
							up_q     <= 1'b1;
							sstart_q <= next_i;
							k_q      <= cnt_q;
							wstart_q <= idx_q[IDX_W-1:0];
							status_q <= ST_DONE;
							rbase_q  <= e.base;
							rpages_q <= n_q;
							state_q  <= S_SHR;
						end
					end else if (kind_q == KIND_RESERVE && !e.in_use &&
						addr_q >= e.base && ext_addr(addr_q) < e_end) begin
						if (rend_q > e_end) begin
							status_q <= ST_NOFIT;
							state_q  <= S_DONE;
						end else if (({1'b0, cnt_q} + (CNT_W+1)'(need)) >
							(CNT_W+1)'(MAX_SEGMENTS)) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							if (has_head) begin
								piece_q[0] <= '{base: e.base, pages: head, in_use: 1'b0};
								piece_q[1] <= '{base: addr_q, pages: n_q, in_use: 1'b1};
							end else begin
								piece_q[0] <= '{base: addr_q, pages: n_q, in_use: 1'b1};
								piece_q[1] <= '{base: rend_q[ADDR_W-1:0],
									pages: e.pages - head - n_q, in_use: 1'b0};
							end
							piece_q[2] <= '{base: rend_q[ADDR_W-1:0],
								pages: e.pages - head - n_q, in_use: 1'b0};
							wn_q     <= need + 2'd1;
							amt_q    <= need;
							up_q     <= 1'b1;
							sstart_q <= next_i;
							k_q      <= cnt_q;
							wstart_q <= idx_q[IDX_W-1:0];
							status_q <= ST_DONE;
							rbase_q  <= addr_q;
							rpages_q <= n_q;
							state_q  <= S_SHR;
						end
					end else if (kind_q == KIND_FREE && e.base == addr_q) begin
						if (!e.in_use) begin
							state_q <= S_DONE;
						end else begin
							mp_q      <= prev_ok_q && !prev_q.in_use &&
								(prev_end_q == ext_addr(e.base)) && !psum[PAGES_W];
							if (prev_ok_q && !prev_q.in_use &&
								(prev_end_q == ext_addr(e.base)) && !psum[PAGES_W]) begin
								mbase_q  <= prev_q.base;
								mpages_q <= psum[PAGES_W-1:0];
							end else begin
								mbase_q  <= e.base;
								mpages_q <= e.pages;
							end
							cur_end_q <= e_end;
							state_q   <= S_RDN;
						end
					end else begin
						prev_q     <= e;
						prev_end_q <= e_end;
						prev_ok_q  <= 1'b1;
						idx_q      <= next_i;
						state_q    <= (next_i == cnt_q) ? S_DONE : S_RD;
					end
				end
				S_RDN: begin
					state_q <= S_EVN;
				end
				S_EVN: begin
					piece_q[0] <= '{base: mbase_q, pages: fpages, in_use: 1'b0};
					wn_q       <= 2'd1;
					wstart_q   <= mp_q ? IDX_W'(idx_q - CNT_W'(1)) : idx_q[IDX_W-1:0];
					amt_q      <= {1'b0, mp_q} + {1'b0, mn};
					up_q       <= 1'b0;
					sstart_q   <= next_i + CNT_W'(mn);
					k_q        <= next_i + CNT_W'(mn);
					status_q   <= ST_DONE;
					rpages_q   <= fpages;
					state_q    <= S_SHR;
				end
				S_SHR: begin
					state_q <= sh_more ? S_SHW : S_PW;
				end
				S_SHW: begin
					k_q     <= up_q ? (k_q - CNT_W'(1)) : (k_q + CNT_W'(1));
					state_q <= S_SHR;
				end
				S_PW: begin
					pw_q <= pw_q + 2'd1;
					if (pw_q == wn_q - 2'd1) begin
						cnt_q   <= up_q ? (cnt_q + CNT_W'(amt_q)) : (cnt_q - CNT_W'(amt_q));
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= '{status: status_q, result_base: rbase_q,
							result_pages: rpages_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
